/* design/color_timeline_interpolator_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the color timeline interpolator
// Shared checks; each use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef COLOR_TIMELINE_INTERPOLATOR_UNIT_MACROS_SVH
`define COLOR_TIMELINE_INTERPOLATOR_UNIT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define CTIU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CTIU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/ctiu_pkg.sv */
// ----------------------------------------------------------------------------
// ctiu_pkg
// Shared constants, types and helpers of the color timeline interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package ctiu_pkg;

  // Key point storage
  localparam int POINT_SLOTS    = 6;
  localparam int MAX_POINTS_DEF = 6;
  localparam int SLOT_W         = 3;
  localparam int POINT_W        = 32;
  localparam int COUNT_W        = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_LAST  = 3'd6;

  // Register reset values
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd3;
  localparam logic [POINT_SLOTS-1:0][POINT_W-1:0] POINT_RESET = {
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hFFFF_00FF, 32'h7F66_FF66, 32'h00FF_00FF
  };

  // Datapath widths
  localparam int TIME_W  = 16;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int NUM_W   = 24;
  localparam int RATIO_W = 8;
  localparam int PROD_W  = 16;
  localparam int SUM_W   = 17;

  typedef logic [POINT_SLOTS-1:0][POINT_W-1:0] point_table_t;

  // Item traveling through the ratio divider
  typedef struct packed {
    logic [NUM_W-1:0]   rem;
    logic [TIME_W-1:0]  den;
    logic [RATIO_W-1:0] quo;
    logic [COLOR_W-1:0] lcol;
    logic [COLOR_W-1:0] rcol;
  } div_t;

  // Widen the 8-bit key time to 16 bits (t * 257)
  function automatic logic [TIME_W-1:0] point_time(input logic [POINT_W-1:0] p);
    return {p[31:24], p[31:24]};
  endfunction

endpackage

`default_nettype wire

/* design/color_timeline_interpolator_unit.sv */
// Throughput: one time value per cycle; the 8-stage ratio divider, two
// search stages and two blend stages each hold one item.
// While a finished result waits on the outputs, empty stages still fill;
// the input stalls only once every stage holds an item.
// Reset (rst, synchronous): empties the pipeline and loads the default
// point count and key point table.
// ----------------------------------------------------------------------------
// color_timeline_interpolator_unit
// Piecewise linear color gradient over up to six configured key points.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_timeline_interpolator_unit_macros.svh"

module color_timeline_interpolator_unit #(
  parameter int MAX_POINTS = ctiu_pkg::MAX_POINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [ctiu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ctiu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ctiu_pkg::TIME_W-1:0]       time_progress,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ctiu_pkg::CHAN_W-1:0]            red,
  output logic [ctiu_pkg::CHAN_W-1:0]            green,
  output logic [ctiu_pkg::CHAN_W-1:0]            blue
);

  logic [ctiu_pkg::COUNT_W-1:0]  point_count;
  ctiu_pkg::point_table_t        points;

  logic                          seg_valid;
  logic                          seg_ready;
  ctiu_pkg::div_t                seg_item;
  logic                          div_valid;
  logic                          div_ready;
  ctiu_pkg::div_t                div_item;
  logic [ctiu_pkg::COLOR_W-1:0]  color;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= ctiu_pkg::COUNT_RESET;
      points      <= ctiu_pkg::POINT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == ctiu_pkg::REG_POINT_COUNT) begin
        point_count <= cfg_data[ctiu_pkg::COUNT_W-1:0];
      end else if (cfg_index <= ctiu_pkg::REG_POINT_LAST) begin
        points[cfg_index - ctiu_pkg::REG_POINT_FIRST] <= cfg_data;
      end
    end
  end

  ctiu_seg_select #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seg (
    .clk          (clk),
    .rst          (rst),
    .point_count  (point_count),
    .points       (points),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .time_progress(time_progress),
    .seg_valid    (seg_valid),
    .seg_ready    (seg_ready),
    .seg_item     (seg_item)
  );

  ctiu_ratio_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (seg_valid),
    .in_ready (seg_ready),
    .in_item  (seg_item),
    .out_valid(div_valid),
    .out_ready(div_ready),
    .out_item (div_item)
  );

  ctiu_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_ready (div_ready),
    .in_item  (div_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .color    (color)
  );

  assign red   = color[23:16];
  assign green = color[15:8];
  assign blue  = color[7:0];

  `CTIU_ASSERT_IMPLY(a_no_stall_when_drained, out_ready, in_ready, "input stalled while output drains")

endmodule

`default_nettype wire

/* design/ctiu_seg_select.sv */
// ----------------------------------------------------------------------------
// ctiu_seg_select
// Two-stage segment search: find the first segment holding the time, then
// form the ratio numerator 255*(t-left) and the span right-left.
// ----------------------------------------------------------------------------
`default_nettype none

module ctiu_seg_select #(
  parameter int MAX_POINTS = ctiu_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [ctiu_pkg::COUNT_W-1:0]        point_count,
  input  wire ctiu_pkg::point_table_t              points,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [ctiu_pkg::TIME_W-1:0]         time_progress,
  output logic                                     seg_valid,
  input  wire logic                                seg_ready,
  output ctiu_pkg::div_t                           seg_item
);

  localparam logic [ctiu_pkg::SLOT_W-1:0] N_MAX = ctiu_pkg::SLOT_W'(MAX_POINTS);
  localparam logic [ctiu_pkg::SLOT_W-1:0] N_MIN = ctiu_pkg::SLOT_W'(2);

  // Stage A registers
  logic                            a_valid;
  logic [ctiu_pkg::TIME_W-1:0]     a_time;
  logic [ctiu_pkg::SLOT_W-1:0]     a_lidx;
  logic [ctiu_pkg::SLOT_W-1:0]     a_ridx;
  logic                            a_hit;
  logic                            a_ready;

  // Stage A search results
  logic [ctiu_pkg::SLOT_W-1:0]     n_eff;
  logic [ctiu_pkg::SLOT_W-1:0]     lidx_next;
  logic [ctiu_pkg::SLOT_W-1:0]     ridx_next;
  logic                            hit_next;

  // Stage B datapath
  logic [ctiu_pkg::POINT_W-1:0]    lp;
  logic [ctiu_pkg::POINT_W-1:0]    rp;
  logic [ctiu_pkg::TIME_W-1:0]     lt;
  logic [ctiu_pkg::TIME_W-1:0]     rt;
  logic [ctiu_pkg::TIME_W-1:0]     span;
  logic [ctiu_pkg::TIME_W-1:0]     t_off;
  ctiu_pkg::div_t                  item_next;

  // Clamp the point count into the usable range
  always_comb begin
    if (point_count < N_MIN) begin
      n_eff = N_MIN;
    end else if (point_count > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = point_count;
    end
  end

  // Pick the first segment that holds the time; clamp to an end otherwise
  always_comb begin
    hit_next  = 1'b0;
    lidx_next = '0;
    for (int i = MAX_POINTS - 2; i >= 0; i--) begin
      if ((ctiu_pkg::SLOT_W'(i + 1) < n_eff) &&
          (time_progress >= ctiu_pkg::point_time(points[i])) &&
          (time_progress <= ctiu_pkg::point_time(points[i + 1]))) begin
        hit_next  = 1'b1;
        lidx_next = ctiu_pkg::SLOT_W'(i);
      end
    end
    if (hit_next) begin
      ridx_next = lidx_next + 1'b1;
    end else begin
      if (time_progress < ctiu_pkg::point_time(points[0])) begin
        lidx_next = '0;
      end else begin
        lidx_next = n_eff - 1'b1;
      end
      ridx_next = lidx_next;
    end
  end

  // Stage handshakes
  assign a_ready  = !a_valid || seg_ready || !seg_valid;
  assign in_ready = a_ready;

  // Stage A: hold the chosen segment
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_time <= time_progress;
      a_lidx <= lidx_next;
      a_ridx <= ridx_next;
      a_hit  <= hit_next;
    end
  end

  // Stage B: numerator and span of the chosen segment
  always_comb begin
    lp    = points[a_lidx];
    rp    = points[a_ridx];
    lt    = ctiu_pkg::point_time(lp);
    rt    = ctiu_pkg::point_time(rp);
    span  = rt - lt;
    t_off = a_time - lt;
    item_next.quo  = '0;
    item_next.lcol = lp[ctiu_pkg::COLOR_W-1:0];
    item_next.rcol = rp[ctiu_pkg::COLOR_W-1:0];
    if (a_hit && (span != '0)) begin
      item_next.rem = {t_off, 8'h00} - {8'h00, t_off};
      item_next.den = span;
    end else begin
      item_next.rem = '0;
      item_next.den = ctiu_pkg::TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (!seg_valid || seg_ready) begin
      seg_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && (!seg_valid || seg_ready)) begin
      seg_item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* design/ctiu_ratio_div.sv */
// ----------------------------------------------------------------------------
// ctiu_ratio_div
// Pipelined restoring divider: one quotient bit per stage, eight stages,
// giving the 8-bit blend ratio with the colors carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_timeline_interpolator_unit_macros.svh"

module ctiu_ratio_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ctiu_pkg::div_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ctiu_pkg::div_t      out_item
);

  localparam int STEPS = ctiu_pkg::RATIO_W;

  ctiu_pkg::div_t stage     [STEPS];
  ctiu_pkg::div_t stage_src [STEPS];
  ctiu_pkg::div_t stage_next[STEPS];
  logic           vld       [STEPS];
  logic           src_vld   [STEPS];
  logic           rdy       [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = STEPS - 1 - k;

    logic [ctiu_pkg::NUM_W-1:0] den_sh;

    // Pick the stage source
    if (k == 0) begin : g_first
      assign stage_src[k] = in_item;
      assign src_vld[k]   = in_valid;
    end else begin : g_rest
      assign stage_src[k] = stage[k-1];
      assign src_vld[k]   = vld[k-1];
    end

    // Ready when empty or the next stage takes the current item
    if (k == STEPS - 1) begin : g_last_rdy
      assign rdy[k] = !vld[k] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end

    // Compare and subtract the shifted divisor
    always_comb begin
      den_sh        = ctiu_pkg::NUM_W'(stage_src[k].den) << BIT;
      stage_next[k] = stage_src[k];
      if (stage_src[k].rem >= den_sh) begin
        stage_next[k].rem      = stage_src[k].rem - den_sh;
        stage_next[k].quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (src_vld[k] && rdy[k]) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[STEPS-1];
  assign out_item  = stage[STEPS-1];

  `CTIU_ASSERT_IMPLY(a_den_nonzero, in_valid, in_item.den != '0, "divider fed a zero span")
  `CTIU_ASSERT_IMPLY(a_rem_below_den, out_valid, out_item.rem < ctiu_pkg::NUM_W'(out_item.den), "remainder not below span")

endmodule

`default_nettype wire

/* design/ctiu_blend.sv */
// ----------------------------------------------------------------------------
// ctiu_blend
// Channel blend: multiply stage, then sum and divide by 255 into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_timeline_interpolator_unit_macros.svh"

module ctiu_blend (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ctiu_pkg::div_t                in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ctiu_pkg::COLOR_W-1:0]       color
);

  localparam int CHANS = 3;

  logic                         m_valid;
  logic                         m_ready;
  logic                         s_ready;
  logic [ctiu_pkg::PROD_W-1:0]  pl  [CHANS];
  logic [ctiu_pkg::PROD_W-1:0]  pr  [CHANS];
  logic [ctiu_pkg::SUM_W-1:0]   sum [CHANS];
  logic [ctiu_pkg::SUM_W-1:0]   adj [CHANS];
  logic [ctiu_pkg::RATIO_W-1:0] inv;

  assign s_ready  = !out_valid || out_ready;
  assign m_ready  = !m_valid || s_ready;
  assign in_ready = m_ready;
  assign inv      = 8'd255 - in_item.quo;

  // Multiply stage: weight left and right channels
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && m_ready) begin
      for (int c = 0; c < CHANS; c++) begin
        pl[c] <= ctiu_pkg::PROD_W'(in_item.lcol[8*c +: 8]) * ctiu_pkg::PROD_W'(inv);
        pr[c] <= ctiu_pkg::PROD_W'(in_item.rcol[8*c +: 8]) *
                 ctiu_pkg::PROD_W'(in_item.quo);
      end
    end
  end

  // Sum and divide by 255 as (x + 1 + x/256) / 256
  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      sum[c] = ctiu_pkg::SUM_W'(pl[c]) + ctiu_pkg::SUM_W'(pr[c]);
      adj[c] = sum[c] + ctiu_pkg::SUM_W'(1) + ctiu_pkg::SUM_W'(sum[c][16:8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_ready) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid && s_ready) begin
      for (int c = 0; c < CHANS; c++) begin
        color[8*c +: 8] <= adj[c][15:8];
      end
    end
  end

  `CTIU_ASSERT_IMPLY(a_sum_range, m_valid, (sum[0] <= 17'd65025) && (sum[1] <= 17'd65025) && (sum[2] <= 17'd65025), "blend sum out of range")

endmodule

`default_nettype wire
